// File: src/kst_pkg.sv
// Package for the keyboard scan translate queue: sizes, command and register codes,
// beat structs and the scan code translation tables.
// No dependencies.
package kst_pkg;

	// Sizes
	localparam int QUEUE_DEPTH = 32;
	localparam int KEY_COUNT   = 256;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int KEY_W       = $clog2(KEY_COUNT);
	localparam int LEVEL_W     = 6;
	localparam int CODE_W      = 8;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 1;

	// Command codes
	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_RAW    = 2'd1;
	localparam logic [1:0] CMD_POP    = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_ENABLED    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SUPPRESS_NUMPAD = 1'b1;

	// Shift adjustment ranges and numpad joystick codes
	localparam logic [CODE_W-1:0] SHIFT_UP_LO  = 8'o100;
	localparam logic [CODE_W-1:0] SHIFT_UP_HI  = 8'o137;
	localparam logic [CODE_W-1:0] SHIFT_UP_ADD = 8'o040;
	localparam logic [CODE_W-1:0] SHIFT_DN_LO  = 8'o060;
	localparam logic [CODE_W-1:0] SHIFT_DN_HI  = 8'o077;
	localparam logic [CODE_W-1:0] SHIFT_DN_SUB = 8'o020;
	localparam logic [CODE_W-1:0] NUMPAD_MASK  = 8'hf8;
	localparam logic [CODE_W-1:0] NUMPAD_CODE  = 8'o210;

	typedef struct packed {
		logic [1:0]       command;
		logic [KEY_W-1:0] key_index;
		logic             key_down;
		logic             shift_held;
		logic             ctrl_held;
		logic             latin_mode;
	} kst_req_t;

	typedef struct packed {
		logic               event_valid;
		logic [CODE_W-1:0]  event_code;
		logic               event_pressed;
		logic               event_ctrl;
		logic               enqueued;
		logic               dropped_full;
		logic [LEVEL_W-1:0] queue_level;
	} kst_rsp_t;

	// One queue entry
	typedef struct packed {
		logic              ctrl;
		logic              pressed;
		logic [CODE_W-1:0] code;
	} kst_entry_t;

	// Translate a host scan code; latin selects the Latin table, else Cyrillic
	function automatic logic [CODE_W-1:0] kst_xlat(input logic [KEY_W-1:0] key,
			input logic latin);
		logic [CODE_W-1:0] code;
		code = '0;
		case (key)
			8'h08: code = 8'o030;
			8'h09: code = 8'o015;
			8'h0d: code = 8'o012;
			8'h20: code = 8'o040;
			8'h23: code = 8'o016;
			8'h24: code = 8'o017;
			8'h25: code = 8'o010;
			8'h26: code = 8'o032;
			8'h27: code = 8'o031;
			8'h28: code = 8'o033;
			8'h2d: code = 8'o023;
			8'h30: code = 8'o060;
			8'h31: code = 8'o061;
			8'h32: code = 8'o062;
			8'h33: code = 8'o063;
			8'h34: code = 8'o064;
			8'h35: code = 8'o065;
			8'h36: code = 8'o066;
			8'h37: code = 8'o067;
			8'h38: code = 8'o070;
			8'h39: code = 8'o071;
			8'h41: code = latin ? 8'o101 : 8'o106;
			8'h42: code = latin ? 8'o102 : 8'o111;
			8'h43: code = latin ? 8'o103 : 8'o123;
			8'h44: code = latin ? 8'o104 : 8'o127;
			8'h45: code = latin ? 8'o105 : 8'o125;
			8'h46: code = latin ? 8'o106 : 8'o101;
			8'h47: code = latin ? 8'o107 : 8'o120;
			8'h48: code = latin ? 8'o110 : 8'o122;
			8'h49: code = latin ? 8'o111 : 8'o133;
			8'h4a: code = latin ? 8'o112 : 8'o117;
			8'h4b: code = latin ? 8'o113 : 8'o114;
			8'h4c: code = latin ? 8'o114 : 8'o104;
			8'h4d: code = latin ? 8'o115 : 8'o120;
			8'h4e: code = latin ? 8'o116 : 8'o124;
			8'h4f: code = latin ? 8'o117 : 8'o135;
			8'h50: code = latin ? 8'o120 : 8'o132;
			8'h51: code = latin ? 8'o121 : 8'o112;
			8'h52: code = latin ? 8'o122 : 8'o113;
			8'h53: code = latin ? 8'o123 : 8'o131;
			8'h54: code = latin ? 8'o124 : 8'o105;
			8'h55: code = latin ? 8'o125 : 8'o107;
			8'h56: code = latin ? 8'o126 : 8'o115;
			8'h57: code = latin ? 8'o127 : 8'o103;
			8'h58: code = latin ? 8'o130 : 8'o136;
			8'h59: code = latin ? 8'o131 : 8'o116;
			8'h5a: code = latin ? 8'o132 : 8'o121;
			8'h61: code = 8'o211;
			8'h62: code = 8'o215;
			8'h63: code = 8'o213;
			8'h64: code = 8'o216;
			8'h66: code = 8'o214;
			8'h67: code = 8'o210;
			8'h68: code = 8'o217;
			8'h69: code = 8'o212;
			8'hba: code = latin ? 8'o052 : 8'o126;
			8'hbc: code = latin ? 8'o074 : 8'o102;
			8'hbd: code = 8'o055;
			8'hbe: code = latin ? 8'o076 : 8'o100;
			8'hdb: code = latin ? 8'o133 : 8'o110;
			8'hdd: code = latin ? 8'o135 : 8'o137;
			8'hde: code = 8'o134;
			default: code = '0;
		endcase
		return code;
	endfunction

	// Apply the shift case change to a translated code
	function automatic logic [CODE_W-1:0] kst_shift_adj(input logic [CODE_W-1:0] code,
			input logic shift);
		logic [CODE_W-1:0] res;
		res = code;
		if (shift && code >= SHIFT_UP_LO && code <= SHIFT_UP_HI) begin
			res = code + SHIFT_UP_ADD;
		end else if (shift && code >= SHIFT_DN_LO && code <= SHIFT_DN_HI) begin
			res = code - SHIFT_DN_SUB;
		end
		return res;
	endfunction

endpackage

// File: src/keyboard_scan_translate_queue.sv
// Keyboard scan translate queue: per-key change detect, table translation, event FIFO.
// Depends on kst_pkg.
//
//   channel   handshake            payload                    direction
//   request   start / busy         request (kst_req_t)        in
//   result    done (strobe)        result  (kst_rsp_t)        out
//   config    cfg_we               cfg_index, cfg_wdata       in
//
// One item per cycle while busy is low. Each accepted item passes the input register,
// which also takes the stored key down bit, then translation and FIFO access, then
// the result register. The key state and FIFO update in the cycle the item is worked,
// so the next item sees them; a key bit written by the previous item is forwarded.
// After reset busy is high while the key down bits are cleared one per cycle, then
// stays low. Reset clears the pointers, the fill count, the valid and done flags and
// the configuration registers; FIFO entries are not cleared. The receiver cannot stall.
module keyboard_scan_translate_queue
	import kst_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  kst_req_t              request,
	output logic                  done,
	output kst_rsp_t              result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic                  valid_s1;
	kst_req_t              req_s1;
	logic                  down_rd_s1;
	logic                  scan_en_q;
	logic                  suppress_q;
	logic                  down_q [KEY_COUNT];
	logic                  clr_busy_q;
	logic [KEY_W-1:0]      clr_idx_q;
	kst_entry_t            fifo_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [CNT_W-1:0]      fill_q;
	logic                  done_q;
	kst_rsp_t              result_q;

	logic                  down_we;
	logic                  push_req;
	logic                  do_push;
	logic                  do_pop;
	logic                  full;
	kst_entry_t            push_entry;
	kst_entry_t            rd_entry;
	logic [CODE_W-1:0]     xl_code;
	logic [CODE_W-1:0]     adj_code;
	logic [CNT_W-1:0]      fill_next;
	kst_rsp_t              rsp_d;

	assign busy = clr_busy_q;

	// Clear the key down bits after reset, one per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == KEY_W'(KEY_COUNT - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Capture the input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= request;
		end
	end

	// Read the stored key bit with the beat; forward a write to the same key
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			if (down_we && req_s1.key_index == request.key_index) begin
				down_rd_s1 <= req_s1.key_down;
			end else begin
				down_rd_s1 <= down_q[request.key_index];
			end
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_en_q  <= 1'b0;
			suppress_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCAN_ENABLED:    scan_en_q  <= cfg_wdata[0];
				REG_SUPPRESS_NUMPAD: suppress_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Translate and decide the queue operation
	assign xl_code  = kst_xlat(req_s1.key_index, req_s1.latin_mode);
	assign adj_code = kst_shift_adj(xl_code, req_s1.shift_held);
	assign full     = (fill_q == CNT_W'(QUEUE_DEPTH));
	assign rd_entry = fifo_q[rd_ptr_q];

	always_comb begin
		down_we    = 1'b0;
		push_req   = 1'b0;
		do_pop     = 1'b0;
		push_entry = '0;
		rsp_d      = '0;
		if (valid_s1) begin
			case (req_s1.command)
				CMD_SAMPLE: begin
					if (scan_en_q) begin
						down_we = 1'b1;
						if (down_rd_s1 != req_s1.key_down && xl_code != '0) begin
							push_req           = 1'b1;
							push_entry.code    = adj_code;
							push_entry.pressed = req_s1.key_down;
							push_entry.ctrl    = req_s1.ctrl_held;
						end
					end
				end
				CMD_RAW: begin
					push_req           = 1'b1;
					push_entry.code    = req_s1.key_index;
					push_entry.pressed = req_s1.key_down;
					push_entry.ctrl    = 1'b0;
				end
				CMD_POP: begin
					if (fill_q != '0) begin
						do_pop = 1'b1;
						if (!(suppress_q && (rd_entry.code & NUMPAD_MASK) == NUMPAD_CODE)) begin
							rsp_d.event_valid   = 1'b1;
							rsp_d.event_code    = rd_entry.code;
							rsp_d.event_pressed = rd_entry.pressed;
							rsp_d.event_ctrl    = rd_entry.ctrl;
						end
					end
				end
				default: ;
			endcase
		end
		do_push            = push_req && !full;
		rsp_d.enqueued     = do_push;
		rsp_d.dropped_full = push_req && full;
		if (do_push) begin
			fill_next = fill_q + 1'b1;
		end else if (do_pop) begin
			fill_next = fill_q - 1'b1;
		end else begin
			fill_next = fill_q;
		end
		rsp_d.queue_level = LEVEL_W'(fill_next);
	end

	// Key down bits
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			down_q[clr_idx_q] <= 1'b0;
		end else if (down_we) begin
			down_q[req_s1.key_index] <= req_s1.key_down;
		end
	end

	// Event storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			fill_q <= fill_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q <= rsp_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// File: src/kst_checker.sv
// Port-level checks for the keyboard scan translate queue, bound to the top level.
// Depends on kst_pkg and keyboard_scan_translate_queue.
module kst_checker
	import kst_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input logic     done,
	input kst_rsp_t result
);

	// Every accepted beat gives a result after the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("accepted beat produced no result");

	// A result only follows an accepted beat
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(start && !busy, 2) && $past(arst_n, 1)))
		else $error("result without accepted beat");

	// A push is either stored or dropped, never both
	a_enq_drop: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.enqueued && result.dropped_full))
		else $error("event both enqueued and dropped");

	// A delivered event comes from a pop, which never pushes
	a_pop_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.event_valid) |-> !(result.enqueued || result.dropped_full))
		else $error("delivery and push in one beat");

endmodule

bind keyboard_scan_translate_queue kst_checker u_kst_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// File: verif/testbench.sv
// Self-checking bench for keyboard_scan_translate_queue: directed and random beats
// against an in-bench model of the key down bits, translation and event FIFO.
// Depends on kst_pkg and the keyboard_scan_translate_queue RTL.
module testbench
	import kst_pkg::*;
();

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SEGMENT_BEATS = 225;
	localparam int MODE_FILL  = 0;
	localparam int MODE_DRAIN = 1;
	localparam int MODE_MIXED = 2;

	// Mirror of the key state and event FIFO; holds the results still awaited
	class kbd_event_mirror;
		bit                scan_on;
		bit                suppress_on;
		bit                key_held [KEY_COUNT];
		kst_entry_t        slots [QUEUE_DEPTH];
		int unsigned       head;
		int unsigned       tail;
		int unsigned       level;
		logic [CODE_W-1:0] latin_map [KEY_COUNT];
		logic [CODE_W-1:0] cyrillic_map [KEY_COUNT];
		int unsigned       mapped_keys [$];
		kst_rsp_t          awaited_results [$];
		kst_rsp_t          outcome;
		int unsigned       mismatches;

		function new();
			logic [CODE_W-1:0] cyr_letters [26];
			cyr_letters = '{8'o106, 8'o111, 8'o123, 8'o127, 8'o125, 8'o101, 8'o120,
				8'o122, 8'o133, 8'o117, 8'o114, 8'o104, 8'o120, 8'o124, 8'o135,
				8'o132, 8'o112, 8'o113, 8'o131, 8'o105, 8'o107, 8'o115, 8'o103,
				8'o136, 8'o116, 8'o121};
			for (int k = 0; k < KEY_COUNT; k++) begin
				latin_map[k]    = '0;
				cyrillic_map[k] = '0;
				key_held[k]     = 1'b0;
			end
			// Keys that translate the same in both layouts
			map_both(8'h08, 8'o030);
			map_both(8'h09, 8'o015);
			map_both(8'h0d, 8'o012);
			map_both(8'h20, 8'o040);
			map_both(8'h23, 8'o016);
			map_both(8'h24, 8'o017);
			map_both(8'h25, 8'o010);
			map_both(8'h26, 8'o032);
			map_both(8'h27, 8'o031);
			map_both(8'h28, 8'o033);
			map_both(8'h2d, 8'o023);
			map_both(8'h61, 8'o211);
			map_both(8'h62, 8'o215);
			map_both(8'h63, 8'o213);
			map_both(8'h64, 8'o216);
			map_both(8'h66, 8'o214);
			map_both(8'h67, 8'o210);
			map_both(8'h68, 8'o217);
			map_both(8'h69, 8'o212);
			map_both(8'hbd, 8'o055);
			map_both(8'hde, 8'o134);
			for (int k = 0; k < 10; k++) begin
				map_both(8'h30 + k, CODE_W'(8'o060 + k));
			end
			// Letters differ per layout
			for (int k = 0; k < 26; k++) begin
				latin_map[8'h41 + k]    = CODE_W'(8'o101 + k);
				cyrillic_map[8'h41 + k] = cyr_letters[k];
			end
			latin_map[8'hba] = 8'o052;  cyrillic_map[8'hba] = 8'o126;
			latin_map[8'hbc] = 8'o074;  cyrillic_map[8'hbc] = 8'o102;
			latin_map[8'hbe] = 8'o076;  cyrillic_map[8'hbe] = 8'o100;
			latin_map[8'hdb] = 8'o133;  cyrillic_map[8'hdb] = 8'o110;
			latin_map[8'hdd] = 8'o135;  cyrillic_map[8'hdd] = 8'o137;
			for (int k = 0; k < KEY_COUNT; k++) begin
				if (latin_map[k] != '0 || cyrillic_map[k] != '0) begin
					mapped_keys.push_back(k);
				end
			end
			scan_on     = 1'b0;
			suppress_on = 1'b0;
			head        = 0;
			tail        = 0;
			level       = 0;
			mismatches  = 0;
		endfunction

		function void map_both(int unsigned key, logic [CODE_W-1:0] code);
			latin_map[key]    = code;
			cyrillic_map[key] = code;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_SCAN_ENABLED:    scan_on = data[0];
				REG_SUPPRESS_NUMPAD: suppress_on = data[0];
				default: ;
			endcase
		endfunction

		// Write one event, or flag it as lost when the FIFO is full
		function void store_event(logic [CODE_W-1:0] ev_code, logic ev_pressed,
				logic ev_ctrl);
			if (level >= QUEUE_DEPTH) begin
				outcome.dropped_full = 1'b1;
				return;
			end
			slots[tail] = '{ctrl: ev_ctrl, pressed: ev_pressed, code: ev_code};
			tail = (tail + 1) % QUEUE_DEPTH;
			level++;
			outcome.enqueued = 1'b1;
		endfunction

		// Advance the state by one accepted beat and queue the result it must give
		function void take_request(kst_req_t q);
			logic [CODE_W-1:0] code;
			kst_entry_t        e;
			bit                was_down;
			outcome = '0;
			case (q.command)
				CMD_SAMPLE: begin
					if (scan_on) begin
						was_down = key_held[q.key_index];
						key_held[q.key_index] = q.key_down;
						code = q.latin_mode ? latin_map[q.key_index]
							: cyrillic_map[q.key_index];
						if (was_down != q.key_down && code != '0) begin
							if (q.shift_held && code >= SHIFT_UP_LO && code <= SHIFT_UP_HI) begin
								code = code + SHIFT_UP_ADD;
							end else if (q.shift_held && code >= SHIFT_DN_LO
									&& code <= SHIFT_DN_HI) begin
								code = code - SHIFT_DN_SUB;
							end
							store_event(code, q.key_down, q.ctrl_held);
						end
					end
				end
				CMD_RAW: store_event(q.key_index, q.key_down, 1'b0);
				CMD_POP: begin
					if (level != 0) begin
						e = slots[head];
						head = (head + 1) % QUEUE_DEPTH;
						level--;
						if (!(suppress_on && (e.code & NUMPAD_MASK) == NUMPAD_CODE)) begin
							outcome.event_valid   = 1'b1;
							outcome.event_code    = e.code;
							outcome.event_pressed = e.pressed;
							outcome.event_ctrl    = e.ctrl;
						end
					end
				end
				default: ;
			endcase
			outcome.queue_level = LEVEL_W'(level);
			awaited_results.push_back(outcome);
		endfunction

		function void report(string what, kst_rsp_t want, kst_rsp_t got);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%s: expected valid=%0b code=%o pressed=%0b ctrl=%0b enq=%0b drop=%0b level=%0d",
					what, want.event_valid, want.event_code, want.event_pressed,
					want.event_ctrl, want.enqueued, want.dropped_full, want.queue_level);
				$display("    got      valid=%0b code=%o pressed=%0b ctrl=%0b enq=%0b drop=%0b level=%0d",
					got.event_valid, got.event_code, got.event_pressed,
					got.event_ctrl, got.enqueued, got.dropped_full, got.queue_level);
			end
		endfunction

		// Match one result beat against the oldest awaited one
		function void compare_result(kst_rsp_t got);
			kst_rsp_t want;
			if (awaited_results.size() == 0) begin
				report("result with nothing awaited", '0, got);
				return;
			end
			want = awaited_results.pop_front();
			if (want.event_valid !== got.event_valid || want.event_code !== got.event_code
					|| want.event_pressed !== got.event_pressed
					|| want.event_ctrl !== got.event_ctrl || want.enqueued !== got.enqueued
					|| want.dropped_full !== got.dropped_full
					|| want.queue_level !== got.queue_level) begin
				report("result mismatch", want, got);
			end
		endfunction

		function int unsigned outstanding();
			return awaited_results.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	kst_req_t              request = '0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  busy;
	logic                  done;
	kst_rsp_t              result;

	kbd_event_mirror mirror;
	bit              idling_on;
	bit              scan_shadow;
	bit              held_keys [KEY_COUNT];
	int unsigned     cycles = 0;

	keyboard_scan_translate_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watch accepted beats, register writes and result strobes
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				mirror.compare_result(result);
			end
			if (cfg_we) begin
				mirror.write_reg(cfg_index, cfg_wdata);
			end
			if (start && !busy) begin
				mirror.take_request(request);
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	function automatic kst_req_t make_req(logic [1:0] cmd, logic [KEY_W-1:0] key,
			logic down, logic shift, logic ctrl, logic latin);
		kst_req_t q;
		q.command    = cmd;
		q.key_index  = key;
		q.key_down   = down;
		q.shift_held = shift;
		q.ctrl_held  = ctrl;
		q.latin_mode = latin;
		return q;
	endfunction

	// Pick a random beat; the mode biases toward filling or draining the FIFO
	function automatic kst_req_t random_req(int mode);
		kst_req_t    q;
		int unsigned roll;
		q = make_req(CMD_SAMPLE, KEY_W'($urandom_range(255)), 1'($urandom_range(1)),
			1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
		roll = $urandom_range(99);
		case (mode)
			MODE_FILL:  q.command = roll < 5 ? CMD_UNUSED : roll < 15 ? CMD_POP
				: roll < 55 ? CMD_RAW : CMD_SAMPLE;
			MODE_DRAIN: q.command = roll < 3 ? CMD_UNUSED : roll < 80 ? CMD_POP
				: roll < 90 ? CMD_RAW : CMD_SAMPLE;
			default:    q.command = roll < 4 ? CMD_UNUSED : roll < 40 ? CMD_POP
				: roll < 65 ? CMD_RAW : CMD_SAMPLE;
		endcase
		if (q.command == CMD_SAMPLE) begin
			if ($urandom_range(99) < 80) begin
				q.key_index = KEY_W'(mirror.mapped_keys[$urandom_range(
					mirror.mapped_keys.size() - 1)]);
			end
			// Mostly real key changes so events get made
			if ($urandom_range(99) < 75) begin
				q.key_down = !held_keys[q.key_index];
			end
		end else if (q.command == CMD_RAW && $urandom_range(99) < 20) begin
			q.key_index = NUMPAD_CODE | KEY_W'($urandom_range(7));
		end
		return q;
	endfunction

	// Drive one beat and hold it until accepted
	task automatic send(kst_req_t q);
		if (idling_on && $urandom_range(99) < 10) begin
			start <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		start   <= 1'b1;
		request <= q;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (q.command == CMD_SAMPLE && scan_shadow) begin
			held_keys[q.key_index] = q.key_down;
		end
	endtask

	// Hold off until every awaited result is in
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (mirror.outstanding() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SCAN_ENABLED) begin
			scan_shadow = data[0];
		end
	endtask

	initial begin
		bit          scan_plan [6];
		bit          suppress_plan [6];
		int unsigned beats;
		int          mode;
		kst_req_t    q;
		mirror        = new();
		scan_plan     = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
		suppress_plan = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
		idling_on     = 1'b1;
		scan_shadow   = 1'b0;
		for (int k = 0; k < KEY_COUNT; k++) begin
			held_keys[k] = 1'b0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Scanning off: samples ignored, unused command, empty pop, zero-code event
		send(make_req(CMD_SAMPLE, 8'h41, 1'b1, 1'b0, 1'b0, 1'b1));
		send(make_req(CMD_UNUSED, 8'hff, 1'b1, 1'b1, 1'b1, 1'b1));
		send(make_req(CMD_POP, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
		send(make_req(CMD_RAW, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0));
		send(make_req(CMD_RAW, 8'hff, 1'b0, 1'b1, 1'b1, 1'b1));
		send(make_req(CMD_POP, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
		write_reg(REG_SCAN_ENABLED, 1'b1);

		// Shift edges, no-change sample, untranslated keys, numpad code
		send(make_req(CMD_SAMPLE, 8'h41, 1'b1, 1'b1, 1'b0, 1'b1));
		send(make_req(CMD_SAMPLE, 8'h41, 1'b1, 1'b0, 1'b0, 1'b1));
		send(make_req(CMD_SAMPLE, 8'h41, 1'b0, 1'b0, 1'b1, 1'b0));
		send(make_req(CMD_SAMPLE, 8'h30, 1'b1, 1'b1, 1'b0, 1'b1));
		send(make_req(CMD_SAMPLE, 8'h39, 1'b1, 1'b1, 1'b0, 1'b0));
		send(make_req(CMD_SAMPLE, 8'hdd, 1'b1, 1'b1, 1'b1, 1'b0));
		send(make_req(CMD_SAMPLE, 8'hbe, 1'b1, 1'b1, 1'b0, 1'b0));
		send(make_req(CMD_SAMPLE, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1));
		send(make_req(CMD_SAMPLE, 8'hff, 1'b1, 1'b0, 1'b1, 1'b1));
		send(make_req(CMD_SAMPLE, 8'h67, 1'b1, 1'b0, 1'b0, 1'b1));
		for (int k = 0; k < 4; k++) begin
			send(make_req(CMD_POP, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
		end
		write_reg(REG_SUPPRESS_NUMPAD, 1'b1);
		for (int k = 0; k < 4; k++) begin
			send(make_req(CMD_POP, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
		end

		// Random segments, each under its own register setting
		for (int seg = 0; seg < 6; seg++) begin
			write_reg(REG_SCAN_ENABLED, scan_plan[seg]);
			write_reg(REG_SUPPRESS_NUMPAD, suppress_plan[seg]);
			idling_on = (seg != 3);
			beats = 0;
			mode  = MODE_MIXED;
			for (int n = 0; beats < SEGMENT_BEATS; n++) begin
				if (n % 40 == 0) begin
					mode = $urandom_range(2);
				end
				q = random_req(mode);
				beats++;
				send(q);
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (mirror.mismatches == 0 && mirror.outstanding() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

// File: files.f
src/kst_pkg.sv
src/keyboard_scan_translate_queue.sv
src/kst_checker.sv
verif/testbench.sv
